@@ sv/ber_tlv_stream_parser_defines.svh @@
// Assertion macros shared by the BER-TLV stream parser modules.
`ifndef BER_TLV_STREAM_PARSER_DEFINES_SVH
`define BER_TLV_STREAM_PARSER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define BTSP_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define BTSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/btsp_pkg.sv @@
// Shared types and constants of the BER-TLV stream parser.
`timescale 1ns / 1ps

package btsp_pkg;

   // Hard cap on the number of entries per message.
   localparam int MAX_ENTRIES = 256;
   // Width that holds both the entry limit register and MAX_ENTRIES.
   localparam int ENTRY_CMP_W = 13;

   // Configuration port layout.
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_ENTRY_LIMIT = 1'b0;
   localparam logic [8:0] ENTRY_LIMIT_RESET = 9'd64;

   // Header byte encodings.
   localparam logic [4:0] TAG_MULTI_BYTE = 5'h1F;
   localparam logic [6:0] LEN_MAX_BYTES = 7'd4;
   localparam logic [7:0] PAD_BYTE = 8'h00;

   // Width of the packed result data.
   localparam int RSP_DATA_W = 104;

   // Status codes of the final record.
   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_TAG_LONG,
      STATUS_LEN_BYTES,
      STATUS_ENTRIES,
      STATUS_DEPTH,
      STATUS_TRUNCATED
   } status_type;

   // One result record.
   typedef struct packed {
      logic [31:0] tag_value;
      logic [31:0] value_length;
      logic [15:0] value_offset;
      logic [3:0]  nesting_depth;
      logic        is_constructed;
      logic [7:0]  entry_index;
      logic        is_final;
      status_type  status;
      logic [8:0]  entry_count;
   } rsp_rec_type;

   // Records produced by the parser for one byte.
   typedef struct packed {
      logic [1:0]  push_cnt;
      rsp_rec_type rec0;
      rsp_rec_type rec1;
   } rec_push_type;

endpackage

@@ sv/btsp_fifo.sv @@
// Small result queue that takes up to two records per cycle while it has room and gives one while out_ready is high.
`timescale 1ns / 1ps
`include "ber_tlv_stream_parser_defines.svh"

module btsp_fifo #(
   parameter int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  btsp_pkg::rec_push_type push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output btsp_pkg::rsp_rec_type out_rec
);

   btsp_pkg::rsp_rec_type mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [PTR_W-1:0] tail_p1, tail_p2;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   // Pointer wrap helper.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign tail_p1 = ptr_inc(tail_ff);
   assign tail_p2 = ptr_inc(tail_p1);

   // Output side reads the head entry directly.
   assign out_valid = (count_ff != '0);
   assign out_rec   = mem_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));

   // Pointer and count update.
   always_comb begin
      head_in  = pop ? ptr_inc(head_ff) : head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + CNT_W'(push.push_cnt) - CNT_W'(pop);
      if (push.push_cnt == 2'd1) begin
         tail_in = tail_p1;
      end else if (push.push_cnt == 2'd2) begin
         tail_in = tail_p2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Record storage, two write slots.
   always_ff @(posedge clock) begin
      if (push.push_cnt != 2'd0) begin
         mem_ff[tail_ff] <= push.rec0;
      end
      if (push.push_cnt == 2'd2) begin
         mem_ff[tail_p1] <= push.rec1;
      end
   end

   `BTSP_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "result queue count overflow")
   `BTSP_ASSERT_ALWAYS(a_push_room, (push.push_cnt == 2'd0) || room, "push into a full result queue")

endmodule

@@ sv/btsp_core.sv @@
// BER-TLV header parser state, one byte per cycle while in_fire is high.
`timescale 1ns / 1ps
`include "ber_tlv_stream_parser_defines.svh"

module btsp_core #(
   parameter int MAX_DEPTH = 8,
   parameter int OFFSET_BITS = 16,
   localparam int DW = $clog2(MAX_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  logic [8:0]             entry_limit,
   output btsp_pkg::rec_push_type push
);

   typedef enum logic [2:0] {
      PH_TAG_FIRST,
      PH_TAG_MORE,
      PH_LEN_FIRST,
      PH_LEN_MORE,
      PH_SKIP,
      PH_FAULT
   } phase_type;

   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [DW-1:0] DEPTH_FULL = DW'(MAX_DEPTH);
   localparam logic [btsp_pkg::ENTRY_CMP_W-1:0] ENTRIES_CAP =
      btsp_pkg::ENTRY_CMP_W'(btsp_pkg::MAX_ENTRIES);

   phase_type              phase_ff, phase_in;
   logic [31:0]            tag_ff, tag_in;
   logic [2:0]             tag_cnt_ff, tag_cnt_in;
   logic [31:0]            len_ff, len_in;
   logic [2:0]             left_ff, left_in;
   logic [31:0]            skip_ff, skip_in;
   logic [31:0]            stack_ff [MAX_DEPTH];
   logic [DW-1:0]          depth_ff, depth_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [8:0]             entries_ff, entries_in;
   btsp_pkg::status_type   fault_ff, fault_in;

   logic [31:0]            offset_ext;
   logic [DW-1:0]          pop_depth;
   logic [btsp_pkg::ENTRY_CMP_W-1:0] limit_ext, lim;
   logic                   at_limit;
   logic [OFFSET_BITS-1:0] offset_inc;
   logic [31:0]            voff;
   logic [15:0]            shown_off;
   logic [1:0]             first_sel;
   logic                   con;
   logic [31:0]            len_val;
   logic [32:0]            end_sum;
   logic [31:0]            end_sat;
   logic                   fin, emit, stack_push;
   btsp_pkg::status_type   status_v;
   btsp_pkg::rsp_rec_type  entry_rec, final_rec;

   // Pop levels whose end has been reached: keep up to the highest open level still ahead.
   assign offset_ext = 32'(offset_ff);
   always_comb begin
      pop_depth = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if ((DW'(i) < depth_ff) && (stack_ff[i] > offset_ext)) begin
            pop_depth = DW'(i + 1);
         end
      end
   end

   // Effective entry limit.
   assign limit_ext = btsp_pkg::ENTRY_CMP_W'(entry_limit);
   assign lim       = (limit_ext > ENTRIES_CAP) ? ENTRIES_CAP : limit_ext;
   assign at_limit  = (btsp_pkg::ENTRY_CMP_W'(entries_ff) >= lim);

   // Saturating offsets.
   assign offset_inc = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + OFFSET_BITS'(1);
   assign voff       = 32'(offset_inc);
   assign shown_off  = (voff > 32'h0000_FFFF) ? 16'hFFFF : voff[15:0];

   // Constructed bit of the tag's first byte.
   assign first_sel = 2'(tag_cnt_ff - 3'd1);
   always_comb begin
      case (first_sel)
         2'd0:    con = tag_ff[5];
         2'd1:    con = tag_ff[13];
         2'd2:    con = tag_ff[21];
         default: con = tag_ff[29];
      endcase
   end

   // Length value as completed by this byte.
   always_comb begin
      case (phase_ff)
         PH_LEN_FIRST: len_val = in_byte[7] ? 32'd0 : {24'd0, in_byte};
         PH_LEN_MORE:  len_val = {len_ff[23:0], in_byte};
         default:      len_val = len_ff;
      endcase
   end

   // End offset of a constructed value, saturating at 32 bits.
   assign end_sum = {1'b0, voff} + {1'b0, len_val};
   assign end_sat = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];

   // Next state for one byte.
   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      tag_cnt_in = tag_cnt_ff;
      len_in     = len_ff;
      left_in    = left_ff;
      skip_in    = skip_ff;
      depth_in   = depth_ff;
      entries_in = entries_ff;
      fault_in   = fault_ff;
      fin        = 1'b0;
      emit       = 1'b0;
      stack_push = 1'b0;

      case (phase_ff)
         PH_TAG_FIRST: begin
            depth_in = pop_depth;
            if (at_limit) begin
               fault_in = btsp_pkg::STATUS_ENTRIES;
               phase_in = PH_FAULT;
            end else if (in_byte != btsp_pkg::PAD_BYTE) begin
               tag_in     = {24'd0, in_byte};
               tag_cnt_in = 3'd1;
               phase_in   = (in_byte[4:0] == btsp_pkg::TAG_MULTI_BYTE) ?
                            PH_TAG_MORE : PH_LEN_FIRST;
            end
         end
         PH_TAG_MORE: begin
            tag_in     = {tag_ff[23:0], in_byte};
            tag_cnt_in = tag_cnt_ff + 3'd1;
            if (!in_byte[7]) begin
               phase_in = PH_LEN_FIRST;
            end else if (tag_cnt_ff >= 3'd3) begin
               fault_in = btsp_pkg::STATUS_TAG_LONG;
               phase_in = PH_FAULT;
            end
         end
         PH_LEN_FIRST: begin
            if (in_byte[7]) begin
               if (in_byte[6:0] > btsp_pkg::LEN_MAX_BYTES) begin
                  fault_in = btsp_pkg::STATUS_LEN_BYTES;
                  phase_in = PH_FAULT;
               end else if (in_byte[6:0] == 7'd0) begin
                  len_in = 32'd0;
                  fin    = 1'b1;
               end else begin
                  len_in   = 32'd0;
                  left_in  = in_byte[2:0];
                  phase_in = PH_LEN_MORE;
               end
            end else begin
               len_in = len_val;
               fin    = 1'b1;
            end
         end
         PH_LEN_MORE: begin
            len_in  = len_val;
            left_in = (left_ff != 3'd0) ? left_ff - 3'd1 : 3'd0;
            if (left_in == 3'd0) begin
               fin = 1'b1;
            end
         end
         PH_SKIP: begin
            skip_in = (skip_ff != 32'd0) ? skip_ff - 32'd1 : 32'd0;
            if (skip_in == 32'd0) begin
               phase_in = PH_TAG_FIRST;
            end
         end
         PH_FAULT: begin
         end
         default: begin
         end
      endcase

      // Header ends on this byte: depth fault, or record it, then descend, skip or await a tag.
      if (fin) begin
         if (con && (depth_ff >= DEPTH_FULL)) begin
            fault_in = btsp_pkg::STATUS_DEPTH;
            phase_in = PH_FAULT;
         end else begin
            emit       = 1'b1;
            entries_in = entries_ff + 9'd1;
            if (con) begin
               stack_push = 1'b1;
               depth_in   = depth_ff + DW'(1);
               phase_in   = PH_TAG_FIRST;
            end else if (len_val != 32'd0) begin
               skip_in  = len_val;
               phase_in = PH_SKIP;
            end else begin
               phase_in = PH_TAG_FIRST;
            end
         end
      end
   end

   // Final status: first fault, else a header cut short, else ok.
   always_comb begin
      if (fault_in != btsp_pkg::STATUS_OK) begin
         status_v = fault_in;
      end else if ((phase_in == PH_TAG_MORE) || (phase_in == PH_LEN_FIRST) ||
                   (phase_in == PH_LEN_MORE)) begin
         status_v = btsp_pkg::STATUS_TRUNCATED;
      end else begin
         status_v = btsp_pkg::STATUS_OK;
      end
   end

   assign offset_in = offset_inc;

   // Records for this byte.
   always_comb begin
      entry_rec                = '0;
      entry_rec.tag_value      = tag_ff;
      entry_rec.value_length   = len_val;
      entry_rec.value_offset   = shown_off;
      entry_rec.nesting_depth  = 4'(depth_ff);
      entry_rec.is_constructed = con;
      entry_rec.entry_index    = entries_ff[7:0];
      entry_rec.status         = btsp_pkg::STATUS_OK;

      final_rec             = '0;
      final_rec.is_final    = 1'b1;
      final_rec.status      = status_v;
      final_rec.entry_count = entries_in;

      push.push_cnt = in_fire ? (2'(emit) + 2'(in_last)) : 2'd0;
      push.rec0     = emit ? entry_rec : final_rec;
      push.rec1     = final_rec;
   end

   // Parser state registers; the final byte starts the next message afresh.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG_FIRST;
         tag_ff     <= '0;
         tag_cnt_ff <= '0;
         len_ff     <= '0;
         left_ff    <= '0;
         skip_ff    <= '0;
         depth_ff   <= '0;
         offset_ff  <= '0;
         entries_ff <= '0;
         fault_ff   <= btsp_pkg::STATUS_OK;
      end else if (in_fire) begin
         if (in_last) begin
            phase_ff   <= PH_TAG_FIRST;
            tag_ff     <= '0;
            tag_cnt_ff <= '0;
            len_ff     <= '0;
            left_ff    <= '0;
            skip_ff    <= '0;
            depth_ff   <= '0;
            offset_ff  <= '0;
            entries_ff <= '0;
            fault_ff   <= btsp_pkg::STATUS_OK;
         end else begin
            phase_ff   <= phase_in;
            tag_ff     <= tag_in;
            tag_cnt_ff <= tag_cnt_in;
            len_ff     <= len_in;
            left_ff    <= left_in;
            skip_ff    <= skip_in;
            depth_ff   <= depth_in;
            offset_ff  <= offset_in;
            entries_ff <= entries_in;
            fault_ff   <= fault_in;
         end
      end
   end

   // Level end stack, written at the current depth on descent.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (in_fire && stack_push && (depth_ff == DW'(i))) begin
            stack_ff[i] <= end_sat;
         end
      end
   end

   `BTSP_ASSERT_ALWAYS(a_depth_bound, depth_ff <= DEPTH_FULL, "nesting depth beyond stack size")
   `BTSP_ASSERT_ALWAYS(a_fault_phase, (fault_ff != btsp_pkg::STATUS_OK) == (phase_ff == PH_FAULT), "fault code and phase disagree")
   `BTSP_ASSERT_NEXT(a_last_clears, in_fire && in_last, (phase_ff == PH_TAG_FIRST) && (entries_ff == 9'd0) && (depth_ff == '0), "state not cleared after final byte")

endmodule

@@ sv/ber_tlv_stream_parser.sv @@
// A request byte is registered, parsed from that register while the queue has room, and its
// records are written into the four-entry result queue that drives rsp. Throughput: one request
// byte per cycle; a byte gives at most two records and the result port drains one per cycle while
// rsp_tready is high, so the queue holds off requests when fewer than two slots are free.
// Reset (synchronous, active high) clears the parser, the queue and sets entry_limit to 64.
// Top level of the BER-TLV stream parser.
`timescale 1ns / 1ps

module ber_tlv_stream_parser #(
   parameter int MAX_DEPTH = 8,
   parameter int OFFSET_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  logic                                req_tlast,  // last_byte
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] tag_value, [63:32] value_length, [79:64] value_offset, [83:80] nesting_depth,
   // [91:84] entry_index, [94:92] status, [103:95] entry_count
   output logic [btsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,  // is_constructed
   output logic                                rsp_tlast,  // is_final
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [btsp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic                  limit_wr;
   logic [8:0]            limit_ff;
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  req_fire;
   logic                  in_fire;
   logic                  room;
   btsp_pkg::rec_push_type push;
   btsp_pkg::rsp_rec_type  out_rec;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign limit_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[btsp_pkg::CSR_ADDR_W-1] == btsp_pkg::CSR_IDX_ENTRY_LIMIT);
   assign csr_prdata = (csr_paddr[btsp_pkg::CSR_ADDR_W-1] == btsp_pkg::CSR_IDX_ENTRY_LIMIT) ?
                       {23'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= btsp_pkg::ENTRY_LIMIT_RESET;
      end else if (limit_wr) begin
         limit_ff <= csr_pwdata[8:0];
      end
   end

   // Request input register; it drains into the parser whenever the queue has room.
   assign in_fire     = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || room;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Parser.
   btsp_core #(
      .MAX_DEPTH   (MAX_DEPTH),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .in_byte     (in_byte_ff),
      .in_last     (in_last_ff),
      .entry_limit (limit_ff),
      .push        (push)
   );

   // Result queue.
   btsp_fifo #(
      .DEPTH (4)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   // Result packing.
   assign rsp_tdata = {out_rec.entry_count, out_rec.status, out_rec.entry_index,
                       out_rec.nesting_depth, out_rec.value_offset,
                       out_rec.value_length, out_rec.tag_value};
   assign rsp_tuser = out_rec.is_constructed;
   assign rsp_tlast = out_rec.is_final;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the BER-TLV stream parser.
`timescale 1ns / 1ps

module tb_top;

   localparam int TLV_MAX_DEPTH = 8;
   localparam logic [btsp_pkg::CSR_ADDR_W-1:0] ENTRY_LIMIT_ADDR =
      btsp_pkg::CSR_ADDR_W'(4 * btsp_pkg::CSR_IDX_ENTRY_LIMIT);

   // Parser phases of the predictor.
   typedef enum logic [2:0] {
      PH_TAG_FIRST,
      PH_TAG_MORE,
      PH_LEN_FIRST,
      PH_LEN_MORE,
      PH_SKIP,
      PH_FAULT
   } parse_phase_type;

   typedef logic [7:0] byte_q_type[$];

   // Predicts the records of the parser and checks the records that come out of it.
   class tlv_record_checker;
      logic [8:0]            entry_limit;
      parse_phase_type       phase;
      logic [31:0]           tag_accum;
      logic [2:0]            tag_bytes;
      logic [31:0]           len_accum;
      logic [2:0]            len_bytes_left;
      logic [31:0]           skip_left;
      logic [31:0]           level_end [TLV_MAX_DEPTH];
      int                    depth;
      logic [15:0]           byte_offset;
      int                    entries_done;
      btsp_pkg::status_type  fault;
      btsp_pkg::rsp_rec_type expected_records[$];
      int                    records_checked;
      int                    mismatches;
      int                    finals_by_status[6];

      function new();
         entry_limit = btsp_pkg::ENTRY_LIMIT_RESET;
         records_checked = 0;
         mismatches = 0;
         foreach (finals_by_status[i]) finals_by_status[i] = 0;
         restart();
      endfunction

      // Parser state at the start of a message.
      function void restart();
         phase = PH_TAG_FIRST;
         tag_accum = '0;
         tag_bytes = '0;
         len_accum = '0;
         len_bytes_left = '0;
         skip_left = '0;
         foreach (level_end[i]) level_end[i] = '0;
         depth = 0;
         byte_offset = '0;
         entries_done = 0;
         fault = btsp_pkg::STATUS_OK;
      endfunction

      function void set_fault(btsp_pkg::status_type code);
         fault = code;
         phase = PH_FAULT;
      endfunction

      function void push_record(logic [31:0] tag, logic [31:0] len, logic [15:0] off,
                                logic [3:0] dep, logic con, logic [7:0] idx, logic fin,
                                btsp_pkg::status_type st, logic [8:0] cnt);
         btsp_pkg::rsp_rec_type rec;
         rec.tag_value = tag;
         rec.value_length = len;
         rec.value_offset = off;
         rec.nesting_depth = dep;
         rec.is_constructed = con;
         rec.entry_index = idx;
         rec.is_final = fin;
         rec.status = st;
         rec.entry_count = cnt;
         expected_records.push_back(rec);
      endfunction

      // Header ends on this byte: depth fault, or emit its entry and open or skip the value.
      function void close_header();
         logic [7:0]  first;
         logic [15:0] voff;
         logic [32:0] level_stop;
         logic        con;
         first = 8'(tag_accum >> (8 * int'((tag_bytes - 3'd1) & 3'd3)));
         con = first[5];
         voff = (byte_offset == 16'hFFFF) ? 16'hFFFF : byte_offset + 16'd1;
         if (con && depth >= TLV_MAX_DEPTH) begin
            set_fault(btsp_pkg::STATUS_DEPTH);
            return;
         end
         push_record(tag_accum, len_accum, voff, 4'(depth), con, 8'(entries_done), 1'b0,
                     btsp_pkg::STATUS_OK, 9'd0);
         entries_done++;
         if (con) begin
            level_stop = {17'd0, voff} + {1'b0, len_accum};
            if (level_stop[32]) level_stop = 33'h0FFFFFFFF;
            level_end[depth] = level_stop[31:0];
            depth++;
            phase = PH_TAG_FIRST;
         end else if (len_accum != 0) begin
            skip_left = len_accum;
            phase = PH_SKIP;
         end else begin
            phase = PH_TAG_FIRST;
         end
      endfunction

      // Advance the predictor by one accepted request byte.
      function void parse_byte(logic [7:0] b, logic last);
         int                   lim;
         int                   cnt;
         btsp_pkg::status_type st;
         lim = (entry_limit > btsp_pkg::MAX_ENTRIES) ? btsp_pkg::MAX_ENTRIES :
               int'(entry_limit);
         case (phase)
            PH_TAG_FIRST: begin
               // Close levels from the innermost out until one whose end is still ahead.
               while (depth > 0 && level_end[depth-1] <= {16'd0, byte_offset}) depth--;
               if (entries_done >= lim) begin
                  set_fault(btsp_pkg::STATUS_ENTRIES);
               end else if (b != btsp_pkg::PAD_BYTE) begin
                  tag_accum = {24'd0, b};
                  tag_bytes = 3'd1;
                  phase = (b[4:0] == btsp_pkg::TAG_MULTI_BYTE) ? PH_TAG_MORE : PH_LEN_FIRST;
               end
            end
            PH_TAG_MORE: begin
               tag_accum = {tag_accum[23:0], b};
               tag_bytes++;
               if (!b[7]) phase = PH_LEN_FIRST;
               else if (tag_bytes >= 3'd4) set_fault(btsp_pkg::STATUS_TAG_LONG);
            end
            PH_LEN_FIRST: begin
               if (b[7]) begin
                  cnt = int'(b[6:0]);
                  if (cnt > int'(btsp_pkg::LEN_MAX_BYTES)) begin
                     set_fault(btsp_pkg::STATUS_LEN_BYTES);
                  end else if (cnt == 0) begin
                     len_accum = '0;
                     close_header();
                  end else begin
                     len_accum = '0;
                     len_bytes_left = 3'(cnt);
                     phase = PH_LEN_MORE;
                  end
               end else begin
                  len_accum = {24'd0, b};
                  close_header();
               end
            end
            PH_LEN_MORE: begin
               len_accum = {len_accum[23:0], b};
               if (len_bytes_left > 0) len_bytes_left--;
               if (len_bytes_left == 0) close_header();
            end
            PH_SKIP: begin
               if (skip_left > 0) skip_left--;
               if (skip_left == 0) phase = PH_TAG_FIRST;
            end
            default: ;
         endcase
         if (byte_offset != 16'hFFFF) byte_offset++;
         // The last byte closes the message with a status record.
         if (last) begin
            if (fault != btsp_pkg::STATUS_OK) st = fault;
            else if (phase == PH_TAG_MORE || phase == PH_LEN_FIRST || phase == PH_LEN_MORE)
               st = btsp_pkg::STATUS_TRUNCATED;
            else st = btsp_pkg::STATUS_OK;
            push_record('0, '0, '0, '0, 1'b0, '0, 1'b1, st, 9'(entries_done));
            restart();
         end
      endfunction

      function string describe(btsp_pkg::rsp_rec_type r);
         return $sformatf("tag %h len %h off %h depth %0d con %b idx %0d final %b st %0d cnt %0d",
                          r.tag_value, r.value_length, r.value_offset, r.nesting_depth,
                          r.is_constructed, r.entry_index, r.is_final, r.status, r.entry_count);
      endfunction

      // Compare one accepted record with the oldest expected one.
      function void check_record(btsp_pkg::rsp_rec_type got);
         btsp_pkg::rsp_rec_type want;
         if (expected_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected record: %s", describe(got));
            return;
         end
         want = expected_records.pop_front();
         records_checked++;
         if (want.is_final) finals_by_status[want.status]++;
         if (got.tag_value !== want.tag_value || got.value_length !== want.value_length ||
             got.value_offset !== want.value_offset ||
             got.nesting_depth !== want.nesting_depth ||
             got.is_constructed !== want.is_constructed ||
             got.entry_index !== want.entry_index || got.is_final !== want.is_final ||
             got.status !== want.status || got.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("record %0d mismatch at %0t", records_checked, $realtime);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [btsp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [btsp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tlv_record_checker sb;
   btsp_pkg::rsp_rec_type rsp_seen;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int msg_count = 0;
   int byte_count = 0;
   int limit_writes = 0;

   ber_tlv_stream_parser DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // Unpack the result bus into a record.
   always_comb begin
      rsp_seen.tag_value = rsp_tdata[31:0];
      rsp_seen.value_length = rsp_tdata[63:32];
      rsp_seen.value_offset = rsp_tdata[79:64];
      rsp_seen.nesting_depth = rsp_tdata[83:80];
      rsp_seen.is_constructed = rsp_tuser;
      rsp_seen.entry_index = rsp_tdata[91:84];
      rsp_seen.is_final = rsp_tlast;
      rsp_seen.status = btsp_pkg::status_type'(rsp_tdata[94:92]);
      rsp_seen.entry_count = rsp_tdata[103:95];
   end

   // Check every accepted result record.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_record(rsp_seen);
   end

   // Result side: random stalls before each record.
   initial begin : rsp_ready_driver
      int gap;
      @(negedge reset);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Send one request byte after a random gap; valid stays high after acceptance.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.parse_byte(b, last);
      byte_count++;
   endtask

   task automatic send_message(input byte_q_type msg);
      for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
      msg_count++;
   endtask

   // Drop valid and wait until every expected record has arrived and the pipeline is empty.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_records.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Write the entry limit register with a setup phase and an access phase.
   task automatic write_entry_limit(input logic [8:0] value);
      wait_until_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ENTRY_LIMIT_ADDR;
      csr_pwdata <= {23'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.entry_limit = value;
      limit_writes++;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Length field in short form, the 0x80 form or a long form of 1 to 4 bytes.
   function automatic byte_q_type encode_length(int len);
      byte_q_type q;
      int         n;
      int         nmin;
      if (len == 0 && $urandom_range(0, 2) == 0) begin
         q.push_back(8'h80);
      end else if (len < 128 && $urandom_range(0, 3) != 0) begin
         q.push_back(8'(len));
      end else begin
         nmin = (len < 256) ? 1 : (len < 65536) ? 2 : (len < 16777216) ? 3 : 4;
         n = $urandom_range(nmin, 4);
         q.push_back(8'h80 | 8'(n));
         for (int k = n - 1; k >= 0; k--) q.push_back(8'(len >> (8 * k)));
      end
      return q;
   endfunction

   // A well-formed TLV with random tag, length form and content, nesting below lvl.
   function automatic byte_q_type gen_tlv(int lvl);
      byte_q_type q;
      byte_q_type body;
      byte_q_type sub;
      logic [7:0] first;
      logic [7:0] b;
      int         nt;
      int         len;
      int         pick;
      bit         con;
      con = (lvl < 9) && ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 9);
      nt = (pick < 6) ? 1 : (pick < 8) ? 2 : (pick < 9) ? 3 : 4;
      first = 8'($urandom);
      first[5] = con;
      if (nt > 1) first[4:0] = btsp_pkg::TAG_MULTI_BYTE;
      else if (first[4:0] == btsp_pkg::TAG_MULTI_BYTE) first[4:0] = 5'($urandom_range(0, 30));
      if (first == btsp_pkg::PAD_BYTE) first = 8'h01;
      q.push_back(first);
      for (int k = 1; k < nt; k++) begin
         b = 8'($urandom);
         b[7] = (k < nt - 1);
         q.push_back(b);
      end
      if (con) begin
         repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 5) == 0) body.push_back(btsp_pkg::PAD_BYTE);
            sub = gen_tlv(lvl + 1);
            body = {body, sub};
         end
      end else begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
         repeat (len) body.push_back(8'($urandom));
      end
      sub = encode_length(body.size());
      q = {q, sub, body};
      return q;
   endfunction

   function automatic byte_q_type gen_message();
      byte_q_type q;
      byte_q_type sub;
      if ($urandom_range(0, 4) == 0) q.push_back(btsp_pkg::PAD_BYTE);
      repeat ($urandom_range(1, 4)) begin
         sub = gen_tlv(0);
         q = {q, sub};
         if ($urandom_range(0, 7) == 0) q.push_back(btsp_pkg::PAD_BYTE);
      end
      return q;
   endfunction

   // Directed messages for the corner cases of the header format.
   task automatic run_directed();
      byte_q_type msg;
      // Plain primitive, padding, a four-byte tag.
      msg = '{8'h04, 8'h02, 8'hAA, 8'hBB};
      send_message(msg);
      msg = '{8'h00, 8'h00, 8'h04, 8'h00, 8'h00};
      send_message(msg);
      msg = '{8'h5F, 8'h81, 8'h82, 8'h03, 8'h01, 8'hFF};
      send_message(msg);
      // Tag too long, then ignored bytes.
      msg = '{8'h1F, 8'h81, 8'h82, 8'h83, 8'h84, 8'h55};
      send_message(msg);
      // Zero length in the 0x80 form and a four-byte long form.
      msg = '{8'h04, 8'h80, 8'h04, 8'h84, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'hBB};
      send_message(msg);
      // Too many length bytes.
      msg = '{8'h04, 8'h85, 8'h01};
      send_message(msg);
      // One level too deep, then exactly the deepest nesting allowed.
      msg.delete();
      repeat (TLV_MAX_DEPTH + 1) msg = {msg, 8'h30, 8'h7F};
      msg = {msg, 8'h04, 8'h00};
      send_message(msg);
      msg.delete();
      repeat (TLV_MAX_DEPTH) msg = {msg, 8'h30, 8'h7F};
      msg = {msg, 8'h04, 8'h00};
      send_message(msg);
      // Headers cut short by the last byte, and a value cut short.
      msg = '{8'h04, 8'h82, 8'h01};
      send_message(msg);
      msg = '{8'h5F};
      send_message(msg);
      msg = '{8'h04};
      send_message(msg);
      msg = '{8'h04, 8'h05, 8'hAA};
      send_message(msg);
      // A child that runs past its parent, an empty constructed value, a lone pad byte.
      msg = '{8'h30, 8'h02, 8'h04, 8'h03, 8'hAA, 8'hBB, 8'hCC, 8'h04, 8'h00};
      send_message(msg);
      msg = '{8'h30, 8'h00, 8'h04, 8'h00};
      send_message(msg);
      msg = '{8'h00};
      send_message(msg);
      // A level end that saturates.
      msg = '{8'h30, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hE4, 8'h01, 8'hAA};
      send_message(msg);
      // The limit counts the parent as well as its children.
      write_entry_limit(9'd1);
      msg = '{8'h30, 8'h02, 8'h04, 8'h00};
      send_message(msg);
      write_entry_limit(9'd0);
      msg = '{8'h04, 8'h00};
      send_message(msg);
      // The full entry count and one entry too many, without idling.
      write_entry_limit(9'd256);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      msg.delete();
      repeat (btsp_pkg::MAX_ENTRIES + 1) msg = {msg, 8'h04, 8'h00};
      send_message(msg);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      write_entry_limit(btsp_pkg::ENTRY_LIMIT_RESET);
   endtask

   // Mostly well-formed messages, some cut short or corrupted, some random noise.
   task automatic run_random();
      byte_q_type msg;
      int         kind;
      int         n;
      while (byte_count < 1800) begin
         if (msg_count % 16 == 0) begin
            case ($urandom_range(0, 7))
               0: write_entry_limit(9'd0);
               1: write_entry_limit(9'd1);
               2: write_entry_limit(9'd3);
               3: write_entry_limit(9'd256);
               4: write_entry_limit(btsp_pkg::ENTRY_LIMIT_RESET);
               default: write_entry_limit(9'($urandom_range(5, 256)));
            endcase
         end
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            msg = gen_message();
         end else if (kind < 85) begin
            msg = gen_message();
            if ($urandom_range(0, 1) == 0) begin
               n = $urandom_range(1, msg.size());
               while (msg.size() > n) void'(msg.pop_back());
            end else begin
               msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
            end
         end else begin
            msg.delete();
            repeat ($urandom_range(1, 16)) msg.push_back(8'($urandom));
         end
         send_message(msg);
      end
   endtask

   initial begin : main_sequence
      int waited;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.expected_records.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.expected_records.size() != 0) begin
         $display("timed out with %0d records outstanding", sb.expected_records.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         repeat (10) @(posedge clock);
         $display("ran %0d messages, %0d request bytes, %0d records checked, %0d limit writes",
                  msg_count, byte_count, sb.records_checked, limit_writes);
         $display("final status: ok %0d, tag %0d, length %0d, entries %0d, depth %0d, cut %0d",
                  sb.finals_by_status[btsp_pkg::STATUS_OK],
                  sb.finals_by_status[btsp_pkg::STATUS_TAG_LONG],
                  sb.finals_by_status[btsp_pkg::STATUS_LEN_BYTES],
                  sb.finals_by_status[btsp_pkg::STATUS_ENTRIES],
                  sb.finals_by_status[btsp_pkg::STATUS_DEPTH],
                  sb.finals_by_status[btsp_pkg::STATUS_TRUNCATED]);
         if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
         end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Testbench completed WITH ERRORS");
         end
         $finish;
      end
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #40_000_000;
      $display("watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/btsp_pkg.sv
sv/btsp_fifo.sv
sv/btsp_core.sv
sv/ber_tlv_stream_parser.sv
dv/tb_top.sv
